// ===== hw/rtl/lmcr_pkg.sv =====
// Shared types, constants and codes for the LED matrix chain refresh block.
package lmcr_pkg;

    localparam int MAX_DISPLAYS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int REQ_W    = 2;
    localparam int COORD_W  = 6;
    localparam int OPC_W    = 4;
    localparam int DATA_W   = 8;
    localparam int TGT_W    = 4;
    localparam int POS_W    = 3;
    localparam int GRID_W   = 4;
    localparam int PLACE_W  = 48;
    localparam int ORIENT_W = 32;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_MAX_W = 6;   // byte address at the largest store
    localparam int LIN_W    = 10;    // byte position before the range check
    localparam int LIM_W    = 11;    // invert byte count before saturation

    localparam logic [REQ_W-1:0] REQ_PIXEL  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INVERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CMD    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLACE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 2'd3;

    typedef struct packed {
        logic [GRID_W-1:0]   cols;
        logic [GRID_W-1:0]   rows;
        logic [PLACE_W-1:0]  place;
        logic [ORIENT_W-1:0] orient;
    } cfg_t;

    // One classified item as queued between front and back.
    typedef struct packed {
        logic [REQ_W-1:0]      kind;
        logic [ADDR_MAX_W-1:0] addr;
        logic [2:0]            bit_sel;
        logic                  value;
        logic [OPC_W-1:0]      opcode;
        logic [DATA_W-1:0]     data;
        logic [TGT_W-1:0]      target;
    } entry_t;

endpackage

// ===== hw/rtl/lmcr_if.sv =====
// Valid/ready channel interfaces for request items and frame items.
interface lmcr_in_if import lmcr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               pixel_value;
    logic [OPC_W-1:0]   opcode;
    logic [DATA_W-1:0]  command_data;
    logic [TGT_W-1:0]   target_display;

    modport source (output valid, req_type, pixel_x, pixel_y, pixel_value, opcode,
                    command_data, target_display, input ready);
    modport sink (input valid, req_type, pixel_x, pixel_y, pixel_value, opcode,
                  command_data, target_display, output ready);
endinterface

interface lmcr_out_if import lmcr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TGT_W-1:0]  frame_target;
    logic [OPC_W-1:0]  register_address;
    logic [DATA_W-1:0] register_data;
    logic              last;

    modport source (output valid, frame_target, register_address, register_data, last,
                    input ready);
    modport sink (input valid, frame_target, register_address, register_data, last,
                  output ready);
endinterface

// ===== hw/rtl/lmcr_front.sv =====
// Front end: accepts request items, locates pixel writes, drops off-grid ones.
module lmcr_front import lmcr_pkg::*; #(
    parameter int MAX_DISPLAYS = MAX_DISPLAYS_DEF
) (
    lmcr_in_if.sink  in_ch,
    input  cfg_t     cfg,
    input  logic     q_full,
    output logic     q_push,
    output entry_t   q_entry
);

    localparam int DEPTH = MAX_DISPLAYS * 8;

    logic [LIN_W-1:0] lin;
    logic             on_grid;

    assign lin = LIN_W'(cfg.cols) * LIN_W'(in_ch.pixel_y) + LIN_W'(in_ch.pixel_x[5:3]);

    assign on_grid = ({1'b0, in_ch.pixel_x[5:3]} < cfg.cols)
                  && ({1'b0, in_ch.pixel_y} < {cfg.rows, 3'b000})
                  && (lin < LIN_W'(DEPTH));

    assign in_ch.ready = !q_full;
    assign q_push = in_ch.valid && !q_full
                 && ((in_ch.req_type != REQ_PIXEL) || on_grid);

    always_comb
    begin
        q_entry.kind    = in_ch.req_type;
        q_entry.addr    = lin[ADDR_MAX_W-1:0];
        q_entry.bit_sel = in_ch.pixel_x[2:0];
        q_entry.value   = in_ch.pixel_value;
        q_entry.opcode  = in_ch.opcode;
        q_entry.data    = in_ch.command_data;
        q_entry.target  = in_ch.target_display;
    end

endmodule

// ===== hw/rtl/lmcr_fifo.sv =====
// Short item queue between front and back.
module lmcr_fifo import lmcr_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   full,
    output logic   empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t        slots [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/lmcr_back.sv =====
// Back end: frame store, invert sweep, tile gather and transform, frame output.
module lmcr_back import lmcr_pkg::*; #(
    parameter int MAX_DISPLAYS = MAX_DISPLAYS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  entry_t   head,
    input  logic     q_empty,
    output logic     q_pop,
    lmcr_out_if.source out_ch
);

    localparam int DEPTH = MAX_DISPLAYS * 8;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PIX_WR = 4'd1;
    localparam logic [3:0] ST_INV_WR = 4'd2;
    localparam logic [3:0] ST_G_RD   = 4'd3;
    localparam logic [3:0] ST_G_WAIT = 4'd4;
    localparam logic [3:0] ST_XF     = 4'd5;
    localparam logic [3:0] ST_EMIT   = 4'd6;

    // Rotate and mirror one tile; row j at bits 8j+7..8j, column i at bit 8j+7-i.
    function automatic logic [63:0] xform(input logic [63:0] t, input logic [3:0] ori);
        logic [63:0] o;
        logic [2:0]  x1, y1, si, sj;
        o = '0;
        for (int yy = 0; yy < 8; yy++)
        begin
            for (int xx = 0; xx < 8; xx++)
            begin
                x1 = ori[2] ? 3'(7 - xx) : 3'(xx);
                y1 = ori[3] ? 3'(7 - yy) : 3'(yy);
                case (ori[1:0])
                    2'd1:    begin si = y1;  sj = ~x1; end
                    2'd2:    begin si = ~x1; sj = ~y1; end
                    2'd3:    begin si = ~y1; sj = x1;  end
                    default: begin si = x1;  sj = y1;  end
                endcase
                o[8 * yy + 7 - xx] = t[{sj, ~si}];
            end
        end
        return o;
    endfunction

    logic [7:0]        mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [7:0]        rd_data_reg;
    logic              rd_hit_reg;
    logic [7:0]        rd_word;

    logic [3:0]        state_reg, state_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [2:0]        bit_reg, bit_next;
    logic              val_reg, val_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [2:0]        row_reg, row_next;
    logic [LIN_W-1:0]  base_reg, base_next;
    logic              tvalid_reg, tvalid_next;
    logic [3:0]        orient_reg, orient_next;
    logic              inb_reg, inb_next;
    logic [63:0]       tile_reg, tile_next;
    logic [63:0]       trows_reg, trows_next;
    logic              out_valid_reg, out_valid_next;
    logic [TGT_W-1:0]  out_target_reg, out_target_next;
    logic [OPC_W-1:0]  out_addr_reg, out_addr_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr, rd_addr;
    logic [7:0]        mem_wdata, pix_mask;
    logic              out_free;
    logic [7:0]        grid_tiles;
    logic [POS_W:0]    chain;
    logic [LIM_W-1:0]  inv_lim;
    logic              inv_done;
    logic [POS_W-1:0]  setup_pos;
    logic [5:0]        setup_place;

    assign rd_word   = rd_hit_reg ? rd_data_reg : 8'h00;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign pix_mask  = 8'h80 >> bit_reg;

    assign grid_tiles = 8'(cfg.cols) * 8'(cfg.rows);
    assign chain = (grid_tiles > 8'(MAX_DISPLAYS)) ? (POS_W + 1)'(MAX_DISPLAYS)
                                                   : (POS_W + 1)'(grid_tiles);
    assign inv_lim = ({grid_tiles, 3'b000} > LIM_W'(DEPTH)) ? LIM_W'(DEPTH)
                                                            : {grid_tiles, 3'b000};
    assign inv_done = ((LIM_W'(addr_reg) + 1'b1) == inv_lim);

    assign setup_place = cfg.place[setup_pos * 6 +: 6];

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        bit_next        = bit_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        tvalid_next     = tvalid_reg;
        orient_next     = orient_reg;
        inb_next        = inb_reg;
        tile_next       = tile_reg;
        trows_next      = trows_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_target_next = out_target_reg;
        out_addr_next   = out_addr_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = rd_word;
        rd_addr         = addr_reg;
        setup_pos       = POS_W'(chain - 1'b1);

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (head.kind)
                        REQ_PIXEL:
                        begin
                            q_pop      = 1'b1;
                            rd_addr    = head.addr[AW-1:0];
                            addr_next  = head.addr[AW-1:0];
                            bit_next   = head.bit_sel;
                            val_next   = head.value;
                            state_next = ST_PIX_WR;
                        end
                        REQ_INVERT:
                        begin
                            q_pop   = 1'b1;
                            rd_addr = '0;
                            addr_next = '0;
                            if (inv_lim != '0)
                            begin
                                state_next = ST_INV_WR;
                            end
                        end
                        REQ_CMD:
                        begin
                            if (out_free)
                            begin
                                q_pop           = 1'b1;
                                out_valid_next  = 1'b1;
                                out_target_next = head.target;
                                out_addr_next   = head.opcode;
                                out_data_next   = head.data;
                                out_last_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                            if (chain != '0)
                            begin
                                pos_next    = setup_pos;
                                row_next    = '0;
                                base_next   = LIN_W'(cfg.cols) * LIN_W'({setup_place[5:3], 3'b000})
                                            + LIN_W'(setup_place[2:0]);
                                tvalid_next = ({1'b0, setup_place[2:0]} < cfg.cols)
                                           && ({1'b0, setup_place[5:3]} < cfg.rows);
                                orient_next = cfg.orient[setup_pos * 4 +: 4];
                                state_next  = ST_G_RD;
                            end
                        end
                    endcase
                end
            end
            ST_PIX_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = val_reg ? (rd_word | pix_mask) : (rd_word & ~pix_mask);
                state_next = ST_IDLE;
            end
            ST_INV_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = ~rd_word;
                rd_addr   = addr_reg + 1'b1;
                addr_next = addr_reg + 1'b1;
                if (inv_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_G_RD:
            begin
                rd_addr    = base_reg[AW-1:0];
                inb_next   = tvalid_reg && (base_reg < LIN_W'(DEPTH));
                state_next = ST_G_WAIT;
            end
            ST_G_WAIT:
            begin
                tile_next[row_reg * 8 +: 8] = inb_reg ? rd_word : 8'h00;
                base_next = base_reg + LIN_W'(cfg.cols);
                row_next  = row_reg + 1'b1;
                state_next = (row_reg == 3'd7) ? ST_XF : ST_G_RD;
            end
            ST_XF:
            begin
                trows_next = xform(tile_reg, orient_reg);
                row_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                setup_pos = pos_reg - 1'b1;
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_target_next = TGT_W'(pos_reg);
                    out_addr_next   = OPC_W'(row_reg) + 1'b1;
                    out_data_next   = trows_reg[row_reg * 8 +: 8];
                    out_last_next   = (pos_reg == '0) && (row_reg == 3'd7);
                    row_next        = row_reg + 1'b1;
                    if (row_reg == 3'd7)
                    begin
                        if (pos_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            pos_next    = setup_pos;
                            base_next   = LIN_W'(cfg.cols) * LIN_W'({setup_place[5:3], 3'b000})
                                        + LIN_W'(setup_place[2:0]);
                            tvalid_next = ({1'b0, setup_place[2:0]} < cfg.cols)
                                       && ({1'b0, setup_place[5:3]} < cfg.rows);
                            orient_next = cfg.orient[setup_pos * 4 +: 4];
                            state_next  = ST_G_RD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            rd_hit_reg    <= vld_reg[rd_addr];
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        bit_reg        <= bit_next;
        val_reg        <= val_next;
        base_reg       <= base_next;
        tvalid_reg     <= tvalid_next;
        orient_reg     <= orient_next;
        inb_reg        <= inb_next;
        tile_reg       <= tile_next;
        trows_reg      <= trows_next;
        out_target_reg <= out_target_next;
        out_addr_reg   <= out_addr_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.frame_target     = out_target_reg;
    assign out_ch.register_address = out_addr_reg;
    assign out_ch.register_data    = out_data_reg;
    assign out_ch.last             = out_last_reg;

    a_out_drop_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(out_ch.ready))
        else $error("output item dropped without being taken");

    a_last_only_pos0: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && row_reg == 3'd7 && pos_reg != '0)
        |=> (out_valid_reg && !out_last_reg))
        else $error("last flagged before chain position zero");

    a_full_gather: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_XF) |-> ($past(state_reg) == ST_G_WAIT && row_reg == '0))
        else $error("transform started before all eight rows gathered");

endmodule

// ===== hw/rtl/led_matrix_chain_refresh_top.sv =====
// LED matrix chain refresh: frame store and display chain frame generator.
//
// Request items enter on in_ch (valid/ready) and are classified into a
// short queue; the executing side drains the queue in order.
// Pixel writes and inverts give no output. A register command gives one
// frame on out_ch, valid from the edge after it is accepted when idle.
// A flush gives eight row frames (addresses 1..8) per chain position,
// positions from highest to lowest; last marks the final frame.
// Per position a flush makes eight reads through the single store port
// (a read state and a wait state per row), one rotate/mirror step, then
// eight sends. A pixel write reads the byte and then writes it back; an
// invert rewrites every byte covered, up to 8 * MAX_DISPLAYS.
// in_ch stays ready while the queue has room, so items are taken while
// earlier work or a waiting frame is still in progress.
// If out_ch stalls, the output register holds the frame and the back end
// waits; the queue fills and then in_ch drops ready.
// Reset clears the store (all dark), the queue and the output register;
// grid is 1x1 and both tables zero. Configure only while idle.
module led_matrix_chain_refresh_top import lmcr_pkg::*; #(
    parameter int MAX_DISPLAYS = MAX_DISPLAYS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lmcr_in_if.sink              in_ch,
    lmcr_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t   cfg_reg;
    logic   q_push, q_pop, q_full, q_empty;
    entry_t q_in, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cols   <= GRID_W'(1);
            cfg_reg.rows   <= GRID_W'(1);
            cfg_reg.place  <= '0;
            cfg_reg.orient <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLS:   cfg_reg.cols   <= cfg_data[GRID_W-1:0];
                CFG_ROWS:   cfg_reg.rows   <= cfg_data[GRID_W-1:0];
                CFG_PLACE:  cfg_reg.place  <= cfg_data[PLACE_W-1:0];
                CFG_ORIENT: cfg_reg.orient <= cfg_data[ORIENT_W-1:0];
                default:    cfg_reg.cols   <= cfg_reg.cols;
            endcase
        end
    end

    lmcr_front #(
        .MAX_DISPLAYS (MAX_DISPLAYS)
    ) u_front (
        .in_ch   (in_ch),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    lmcr_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    lmcr_back #(
        .MAX_DISPLAYS (MAX_DISPLAYS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

// ===== sim/led_matrix_chain_refresh_top_tb.sv =====
// Self-checking testbench for the LED matrix chain refresh block: directed table, then random phases.
module led_matrix_chain_refresh_top_tb;
    import lmcr_pkg::*;

    localparam int STORE_BITS = MAX_DISPLAYS_DEF * 64;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int BCAST_TARGET = 8;
    localparam logic [1:0] ROT_0 = 2'd0;
    localparam logic [1:0] ROT_90 = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               v;
        logic [OPC_W-1:0]   op;
        logic [DATA_W-1:0]  cd;
        logic [TGT_W-1:0]   tg;
    } request_t;

    typedef struct packed {
        logic [TGT_W-1:0]  target;
        logic [OPC_W-1:0]  addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } frame_t;

    typedef struct packed {
        request_t rq;
        logic     typed;
        frame_t   want;
    } dir_row_t;

    typedef struct {
        int              cols;
        int              rows;
        logic [47:0]     place;
        logic [31:0]     orient;
        int              send_pct;
        int              recv_pct;
    } phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic recv_ready = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    bit pix [STORE_BITS];
    int grid_cols;
    int grid_rows;
    logic [47:0] place_tbl;
    logic [31:0] orient_tbl;
    frame_t frames_due [$];
    dir_row_t directed [$];
    phase_t phases [$];

    lmcr_in_if in_ch ();
    lmcr_out_if out_ch ();

    assign out_ch.ready = recv_ready;

    led_matrix_chain_refresh_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pixel_pos(input int x, input int y);
        int w;
        w = grid_cols * 8;
        if (x >= w || y >= grid_rows * 8)
            return -1;
        if (w * y + x >= STORE_BITS)
            return -1;
        return w * y + x;
    endfunction

    function automatic int chain_len();
        int n;
        n = grid_cols * grid_rows;
        return (n > MAX_DISPLAYS_DEF) ? MAX_DISPLAYS_DEF : n;
    endfunction

    function automatic logic [7:0][7:0] tile_rows(input int pos);
        logic [5:0] pl;
        logic [3:0] ori;
        logic [7:0][7:0] rows;
        int ox;
        int oy;
        int xx;
        int yy;
        int p;
        pl = place_tbl[6*pos +: 6];
        ori = orient_tbl[4*pos +: 4];
        ox = int'(pl[2:0]) * 8;
        oy = int'(pl[5:3]) * 8;
        rows = '0;
        for (int i = 0; i < 8; i++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                p = pixel_pos(ox + i, oy + j);
                case (ori[1:0])
                    ROT_90:  begin xx = 7 - j; yy = i;     end
                    ROT_180: begin xx = 7 - i; yy = 7 - j; end
                    ROT_270: begin xx = j;     yy = 7 - i; end
                    default: begin xx = i;     yy = j;     end
                endcase
                if (ori[2])
                    xx = 7 - xx;
                if (ori[3])
                    yy = 7 - yy;
                if (p >= 0 && pix[p])
                    rows[yy][7 - xx] = 1'b1;
            end
        end
        return rows;
    endfunction

    // Updates the store model and queues the frames the item will produce.
    task automatic apply_request(input request_t rq);
        int p;
        int n;
        logic [7:0][7:0] rows;
        case (rq.kind)
            REQ_PIXEL:
            begin
                p = pixel_pos(rq.x, rq.y);
                if (p >= 0)
                    pix[p] = rq.v;
            end
            REQ_INVERT:
            begin
                n = grid_cols * 8 * grid_rows * 8;
                if (n > STORE_BITS)
                    n = STORE_BITS;
                for (int b = 0; b < n; b++)
                    pix[b] = !pix[b];
            end
            REQ_CMD:
                frames_due.push_back({rq.tg, rq.op, rq.cd, 1'b1});
            default:
            begin
                for (int k = chain_len(); k > 0; k--)
                begin
                    rows = tile_rows(k - 1);
                    for (int r = 0; r < 8; r++)
                        frames_due.push_back({4'(k - 1), 4'(r + 1), rows[r],
                                              (k == 1 && r == 7)});
                end
            end
        endcase
    endtask

    function automatic request_t mk_req(input logic [REQ_W-1:0] kind, input int x, input int y,
                                        input int v, input int op, input int cd, input int tg);
        return {kind, 6'(x), 6'(y), 1'(v), 4'(op), 8'(cd), 4'(tg)};
    endfunction

    function automatic frame_t mk_frame(input int tg, input int addr, input int data,
                                        input int last);
        return {4'(tg), 4'(addr), 8'(data), 1'(last)};
    endfunction

    function automatic int coord_pick(input int span);
        if (span > 0 && $urandom_range(9) < 8)
            return $urandom_range((span > 64) ? 63 : span - 1, 0);
        return $urandom_range(63, 0);
    endfunction

    function automatic request_t rand_request();
        request_t rq;
        int pick;
        rq = $bits(request_t)'($urandom);
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            rq.kind = REQ_PIXEL;
            rq.x = 6'(coord_pick(grid_cols * 8));
            rq.y = 6'(coord_pick(grid_rows * 8));
            rq.v = ($urandom_range(3) != 0);
        end
        else if (pick < 63)
            rq.kind = REQ_INVERT;
        else if (pick < 80)
        begin
            rq.kind = REQ_CMD;
            if ($urandom_range(1) == 0)
                rq.tg = 4'($urandom_range(BCAST_TARGET, 0));
        end
        else
            rq.kind = REQ_FLUSH;
        return rq;
    endfunction

    function automatic logic [47:0] fitted_place(input int cols, input int rows);
        logic [47:0] pl;
        int cmax;
        int rmax;
        cmax = (cols > 8) ? 7 : cols - 1;
        rmax = (rows > 8) ? 7 : rows - 1;
        for (int p = 0; p < 8; p++)
        begin
            pl[6*p +: 3] = 3'($urandom_range(cmax, 0));
            pl[6*p + 3 +: 3] = 3'($urandom_range(rmax, 0));
        end
        return pl;
    endfunction

    task automatic send_request(input request_t rq);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= rq.kind;
        in_ch.pixel_x <= rq.x;
        in_ch.pixel_y <= rq.y;
        in_ch.pixel_value <= rq.v;
        in_ch.opcode <= rq.op;
        in_ch.command_data <= rq.cd;
        in_ch.target_display <= rq.tg;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_COLS:  grid_cols = int'(value[3:0]);
            CFG_ROWS:  grid_rows = int'(value[3:0]);
            CFG_PLACE: place_tbl = value[47:0];
            default:   orient_tbl = value[31:0];
        endcase
    endtask

    // output side: random ready, compare every accepted frame
    always @(posedge clk)
    begin
        frame_t exp_f;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("unexpected frame: target %0d addr %0d data %02h last %0d",
                           out_ch.frame_target, out_ch.register_address,
                           out_ch.register_data, out_ch.last);
                    mismatches++;
                end
                else
                begin
                    exp_f = frames_due.pop_front();
                    if (out_ch.frame_target !== exp_f.target)
                    begin
                        $error("frame_target: expected %0d, got %0d",
                               exp_f.target, out_ch.frame_target);
                        mismatches++;
                    end
                    if (out_ch.register_address !== exp_f.addr)
                    begin
                        $error("register_address: expected %0d, got %0d",
                               exp_f.addr, out_ch.register_address);
                        mismatches++;
                    end
                    if (out_ch.register_data !== exp_f.data)
                    begin
                        $error("register_data: expected %02h, got %02h",
                               exp_f.data, out_ch.register_data);
                        mismatches++;
                    end
                    if (out_ch.last !== exp_f.last)
                    begin
                        $error("last: expected %0d, got %0d", exp_f.last, out_ch.last);
                        mismatches++;
                    end
                end
            end
            recv_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** led_matrix_chain_refresh_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        request_t rq;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_PIXEL;
        in_ch.pixel_x = '0;
        in_ch.pixel_y = '0;
        in_ch.pixel_value = 1'b0;
        in_ch.opcode = '0;
        in_ch.command_data = '0;
        in_ch.target_display = '0;
        for (int b = 0; b < STORE_BITS; b++)
            pix[b] = 1'b0;
        grid_cols = 1;
        grid_rows = 1;
        place_tbl = '0;
        orient_tbl = '0;

        // 1x1 grid after reset; command rows carry their echo as expectation
        directed.push_back({mk_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_CMD, 0, 0, 0, 0, 0, 0), 1'b1, mk_frame(0, 0, 0, 1)});
        directed.push_back({mk_req(REQ_CMD, 0, 0, 0, 15, 255, 8), 1'b1,
                            mk_frame(8, 15, 255, 1)});
        directed.push_back({mk_req(REQ_CMD, 0, 0, 0, 10, 'ha5, 15), 1'b1,
                            mk_frame(15, 10, 'ha5, 1)});
        directed.push_back({mk_req(REQ_CMD, 63, 63, 1, 9, 'h5a, 9), 1'b1,
                            mk_frame(9, 9, 'h5a, 1)});
        directed.push_back({mk_req(REQ_PIXEL, 0, 0, 1, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_PIXEL, 7, 7, 1, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_PIXEL, 8, 0, 1, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_PIXEL, 0, 63, 1, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_PIXEL, 63, 63, 1, 15, 255, 15), 1'b0,
                            mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_PIXEL, 3, 5, 1, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_PIXEL, 6, 1, 1, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_FLUSH, 63, 63, 1, 15, 255, 15), 1'b0,
                            mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_PIXEL, 3, 5, 0, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_INVERT, 63, 63, 1, 15, 255, 15), 1'b0,
                            mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_PIXEL, 1, 2, 0, 15, 255, 15), 1'b0,
                            mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_INVERT, 0, 0, 0, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});
        directed.push_back({mk_req(REQ_FLUSH, 0, 0, 0, 0, 0, 0), 1'b0, mk_frame(0, 0, 0, 0)});

        phases.push_back('{2, 2, fitted_place(2, 2), {$urandom}, 36, 86});
        phases.push_back('{8, 1, fitted_place(8, 1), {$urandom}, 36, 86});
        phases.push_back('{0, 3, 48'({$urandom, $urandom}), {$urandom}, 86, 36});
        phases.push_back('{15, 15, 48'hffff_ffff_ffff, 32'hffff_ffff, 86, 36});
        phases.push_back('{1, 8, fitted_place(1, 8), {$urandom}, 86, 36});
        phases.push_back('{3, 3, 48'({$urandom, $urandom}), {$urandom}, 0, 0});
        phases.push_back('{8, 8, 48'h0, 32'h0, 0, 0});
        phases.push_back('{4, 2, fitted_place(4, 2), {$urandom}, 0, 0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 86;
        foreach (directed[i])
        begin
            send_request(directed[i].rq);
            if (directed[i].typed)
                frames_due.push_back(directed[i].want);
            else
                apply_request(directed[i].rq);
        end

        foreach (phases[ph])
        begin
            drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_reg(CFG_COLS, CFG_W'(phases[ph].cols));
            write_reg(CFG_ROWS, CFG_W'(phases[ph].rows));
            write_reg(CFG_PLACE, CFG_W'(phases[ph].place));
            write_reg(CFG_ORIENT, CFG_W'(phases[ph].orient));
            cfg_we <= 1'b0;
            send_idle_pct = phases[ph].send_pct;
            recv_idle_pct = phases[ph].recv_pct;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == 12 || $urandom_range(49) == 0)
                    drain();
                rq = rand_request();
                send_request(rq);
                apply_request(rq);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (frames_due.size() != 0)
        begin
            rq = '0;
            $error("frame never produced: target %0d addr %0d data %02h",
                   frames_due[0].target, frames_due[0].addr, frames_due[0].data);
            void'(frames_due.pop_front());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** led_matrix_chain_refresh_top: PASSED **");
        else
            $display("** led_matrix_chain_refresh_top: FAILED **");
        $finish;
    end

endmodule
